@@ hdl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// shared widths, register indexes, opcodes and types of the letterbox mapper
// ----------------------------------------------------------------------------
package lcm_pkg;

  localparam int SIZE_BITS  = 13;
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_FRAC = 24;
  localparam int CFG_W      = SIZE_BITS + 1;          // size register width
  localparam int COORD_W    = SIZE_BITS + FRAC_BITS;  // Q13.16 coordinate
  localparam int SCALE_W    = CFG_W + SCALE_FRAC;     // Q14.24 scale
  localparam int HI_W       = SCALE_W - SCALE_FRAC;
  localparam int OFF_W      = COORD_W;
  localparam int QBITS      = 33;                     // quotient bits kept
  localparam int MAG0_W     = COORD_W + HI_W + 1;     // forward map magnitude
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int OUT_W      = 32;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_TGT_W  = 3'd2;
  localparam logic [2:0] REG_TGT_H  = 3'd3;
  localparam logic [2:0] REG_KEEP   = 3'd4;

  localparam logic OP_S2D = 1'b0;
  localparam logic OP_D2S = 1'b1;

  localparam logic [OUT_W-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [OUT_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [OFF_W-1:0]   offset_x;
    logic [OFF_W-1:0]   offset_y;
    logic               busy;
  } lcm_params_t;

  typedef struct packed {
    logic               op;
    logic               neg;
    logic [COORD_W-1:0] operand;
    logic [SCALE_W-1:0] scl;
    logic [OFF_W-1:0]   off;
  } lcm_item_t;

  // zero reads as one, anything above the largest size is clipped
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > (CFG_W'(1) << SIZE_BITS)) begin
      r = CFG_W'(1) << SIZE_BITS;
    end
    return r;
  endfunction

endpackage

@@ hdl/lcm_cfg.sv @@
// ----------------------------------------------------------------------------
// lcm_cfg
// register file and serial derivation of scales and centring offsets
// ----------------------------------------------------------------------------
module lcm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcm_pkg::DATA_W-1:0]  pwdata,
  output logic [lcm_pkg::DATA_W-1:0]  prdata,
  output lcm_pkg::lcm_params_t        params
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MIN  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OFF  = 3'd4;
  localparam int CW = lcm_pkg::CFG_W;
  localparam int SW = lcm_pkg::SCALE_W;
  localparam int PW = SW + CW;

  logic [CW-1:0] src_w, src_h, tgt_w, tgt_h;
  logic          keep;
  logic [2:0]    state;
  logic          sel;
  logic [5:0]    cnt;
  logic [CW-1:0] rem;
  logic [SW-1:0] quo;
  logic [SW-1:0] scale_x, scale_y;
  logic [lcm_pkg::OFF_W-1:0] offset_x, offset_y;
  logic [PW-1:0] prod;

  logic          wr;
  logic [2:0]    idx;
  logic [CW-1:0] s_eff, t_eff;
  logic [SW-1:0] dividend, scl_sel, quo_next, full, gap;
  logic [CW:0]   rem_sh;
  logic          ge;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_comb begin
    s_eff    = lcm_pkg::eff_size(sel ? src_h : src_w);
    t_eff    = lcm_pkg::eff_size(sel ? tgt_h : tgt_w);
    scl_sel  = sel ? scale_y : scale_x;
    dividend = {t_eff, {lcm_pkg::SCALE_FRAC{1'b0}}};
    rem_sh   = {rem, dividend[SW - 1 - int'(cnt)]};
    ge       = rem_sh >= {1'b0, s_eff};
    quo_next = {quo[SW-2:0], ge};
    full     = dividend;
    gap      = ({{CW{1'b0}}, full} >= prod) ? SW'({{CW{1'b0}}, full} - prod) : '0;
  end

  always_comb begin
    case (idx)
      lcm_pkg::REG_SRC_W: prdata = 32'(src_w);
      lcm_pkg::REG_SRC_H: prdata = 32'(src_h);
      lcm_pkg::REG_TGT_W: prdata = 32'(tgt_w);
      lcm_pkg::REG_TGT_H: prdata = 32'(tgt_h);
      lcm_pkg::REG_KEEP:  prdata = 32'(keep);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= CW'(1920);
      src_h <= CW'(1080);
      tgt_w <= CW'(640);
      tgt_h <= CW'(640);
      keep  <= 1'b1;
      state <= ST_DIV;
      sel   <= 1'b0;
      cnt   <= '0;
      rem   <= '0;
    end else if (wr && idx <= lcm_pkg::REG_KEEP) begin
      case (idx)
        lcm_pkg::REG_SRC_W: src_w <= pwdata[CW-1:0];
        lcm_pkg::REG_SRC_H: src_h <= pwdata[CW-1:0];
        lcm_pkg::REG_TGT_W: tgt_w <= pwdata[CW-1:0];
        lcm_pkg::REG_TGT_H: tgt_h <= pwdata[CW-1:0];
        default:            keep  <= pwdata[0];
      endcase
      state <= ST_DIV;
      sel   <= 1'b0;
      cnt   <= '0;
      rem   <= '0;
    end else begin
      case (state)
        ST_DIV: begin
          quo <= quo_next;
          if (cnt == 6'(SW - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (sel) begin
              scale_y <= quo_next;
              sel     <= 1'b0;
              state   <= ST_MIN;
            end else begin
              scale_x <= quo_next;
              sel     <= 1'b1;
            end
          end else begin
            rem <= ge ? CW'(rem_sh - {1'b0, s_eff}) : rem_sh[CW-1:0];
            cnt <= cnt + 6'd1;
          end
        end
        ST_MIN: begin
          if (keep) begin
            scale_x <= (scale_x < scale_y) ? scale_x : scale_y;
            scale_y <= (scale_x < scale_y) ? scale_x : scale_y;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= scl_sel * s_eff;
          state <= ST_OFF;
        end
        ST_OFF: begin
          if (sel) begin
            offset_y <= gap[SW-1:lcm_pkg::SCALE_FRAC + 1 - lcm_pkg::FRAC_BITS];
            sel      <= 1'b0;
            state    <= ST_IDLE;
          end else begin
            offset_x <= gap[SW-1:lcm_pkg::SCALE_FRAC + 1 - lcm_pkg::FRAC_BITS];
            sel      <= 1'b1;
            state    <= ST_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign params.scale_x  = scale_x;
  assign params.scale_y  = scale_y;
  assign params.offset_x = offset_x;
  assign params.offset_y = offset_y;
  assign params.busy     = state != ST_IDLE;

endmodule

@@ hdl/lcm_front.sv @@
// ----------------------------------------------------------------------------
// lcm_front
// accepts coordinates, picks axis constants and sign, queues work items
// ----------------------------------------------------------------------------
module lcm_front #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,
  input  logic [1:0]                   s_tuser,
  input  lcm_pkg::lcm_params_t         params,
  output logic                         head_valid,
  output lcm_pkg::lcm_item_t           head,
  input  logic                         pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcm_pkg::lcm_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  lcm_pkg::lcm_item_t item;
  logic [lcm_pkg::COORD_W-1:0] coord;
  logic push;

  assign coord    = s_tdata[lcm_pkg::COORD_W-1:0];
  assign s_tready = (count != CNT_W'(DEPTH)) && !params.busy;
  assign push     = s_tvalid && s_tready;
  assign head_valid = count != '0;
  assign head     = mem[rd_ptr];

  // classify: pick the axis constants, fold the sign of the band distance
  always_comb begin
    item.op  = s_tuser[0];
    item.scl = s_tuser[1] ? params.scale_x : params.scale_y;
    item.off = s_tuser[1] ? params.offset_x : params.offset_y;
    item.neg = 1'b0;
    item.operand = coord;
    if (item.op == lcm_pkg::OP_D2S) begin
      if (item.scl == '0) begin
        item.scl = lcm_pkg::SCALE_W'(1);
      end
      if (coord >= item.off) begin
        item.operand = coord - item.off;
      end else begin
        item.operand = item.off - coord;
        item.neg     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/lcm_back.sv @@
// ----------------------------------------------------------------------------
// lcm_back
// multiply path and pipelined restoring divider, saturation, output register
// ----------------------------------------------------------------------------
module lcm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  lcm_pkg::lcm_item_t   head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic [0:0]           m_tuser
);

  localparam int N   = lcm_pkg::QBITS;
  localparam int SW  = lcm_pkg::SCALE_W;
  localparam int CW  = lcm_pkg::COORD_W;
  localparam int SF  = lcm_pkg::SCALE_FRAC;
  localparam int HW  = lcm_pkg::HI_W;
  localparam int MW  = lcm_pkg::MAG0_W;
  localparam int LOW = N - SF;              // coordinate bits brought down
  localparam int TOP = CW - LOW;            // bits of the first partial remainder
  localparam logic [N-1:0] POS_LIM_EXT = N'(lcm_pkg::POS_LIMIT);
  localparam logic [N-1:0] NEG_LIM_EXT = N'(lcm_pkg::NEG_LIMIT);

  logic advance;
  logic v0;
  lcm_pkg::lcm_item_t it0;

  logic               v1, op1, neg1, ovf1;
  logic [HW+CW-1:0]   phi1;
  logic [SF+CW-1:0]   plo1;
  logic [lcm_pkg::OFF_W-1:0] off1;

  logic               dv   [N+1];
  logic               dop  [N+1];
  logic               dneg [N+1];
  logic               dovf [N+1];
  logic [SW-1:0]      dr   [N+1];
  logic [N-1:0]       dq   [N+1];
  logic [LOW-1:0]     dlow [N+1];
  logic [SW-1:0]      dscl [N+1];
  logic [MW-1:0]      dmag [1:N];

  logic [31:0] val;
  logic        sat;
  logic [N-1:0] lim, qm;

  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (advance) begin
      v0 <= head_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      it0     <= head;
      op1     <= it0.op;
      neg1    <= it0.neg;
      phi1    <= it0.operand * it0.scl[SW-1:SF];
      plo1    <= it0.operand * it0.scl[SF-1:0];
      off1    <= it0.off;
      ovf1    <= {{(SW-TOP){1'b0}}, it0.operand[CW-1:LOW]} >= it0.scl;
      dr[0]   <= {{(SW-TOP){1'b0}}, it0.operand[CW-1:LOW]};
      dlow[0] <= it0.operand[LOW-1:0];
      dscl[0] <= it0.scl;
    end
  end

  assign dv[0]   = v1;
  assign dop[0]  = op1;
  assign dneg[0] = neg1;
  assign dovf[0] = ovf1;
  assign dq[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int K = N - 1 - i;
    logic          bitin, ge;
    logic [SW:0]   rsh;
    logic [MW-1:0] mag_in;

    if (K >= SF) begin : g_bd
      assign bitin = dlow[i][K-SF];
    end else begin : g_zero
      assign bitin = 1'b0;
    end

    if (i == 0) begin : g_sum
      assign mag_in = MW'(phi1) + MW'(plo1[SF+CW-1:SF]) + MW'(off1);
    end else begin : g_carry
      assign mag_in = dmag[i];
    end

    assign rsh = {dr[i], bitin};
    assign ge  = rsh >= {1'b0, dscl[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (advance) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dop[i+1]  <= dop[i];
        dneg[i+1] <= dneg[i];
        dovf[i+1] <= dovf[i];
        dr[i+1]   <= ge ? SW'(rsh - {1'b0, dscl[i]}) : rsh[SW-1:0];
        dq[i+1]   <= {dq[i][N-2:0], ge};
        dlow[i+1] <= dlow[i];
        dscl[i+1] <= dscl[i];
        dmag[i+1] <= mag_in;
      end
    end
  end

  // saturate to the signed 32-bit range
  always_comb begin
    lim = dneg[N] ? NEG_LIM_EXT : POS_LIM_EXT;
    qm  = dq[N];
    sat = 1'b0;
    val = '0;
    if (dop[N] == lcm_pkg::OP_S2D) begin
      sat = dmag[N] > MW'(lcm_pkg::POS_LIMIT);
      val = sat ? lcm_pkg::POS_LIMIT : dmag[N][31:0];
    end else if (dovf[N]) begin
      sat = 1'b1;
      val = dneg[N] ? lcm_pkg::NEG_LIMIT : lcm_pkg::POS_LIMIT;
    end else begin
      sat = qm > lim;
      if (sat) begin
        qm = lim;
      end
      val = dneg[N] ? (32'd0 - qm[31:0]) : qm[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= val;
      m_tuser[0] <= sat;
    end
  end

endmodule

@@ hdl/letterbox_coordinate_map_unit.sv @@
// throughput: one coordinate per cycle while the result stream is not stalled and
//   the constants are not being re-derived, set by the 33-stage divider pipeline
//   and the two-multiplier forward path, both fully pipelined
// reset: synchronous; afterwards and after each register write the scales and
//   offsets are re-derived, during which s_tready stays low
// ----------------------------------------------------------------------------
// letterbox_coordinate_map_unit
// maps coordinates between source and letterboxed destination images
// ----------------------------------------------------------------------------
module letterbox_coordinate_map_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [28:0] coord_in, rest zero
  input  logic [1:0]  s_tuser,   // [0] op, [1] axis_is_x
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] coord_out
  output logic [0:0]  m_tuser,   // [0] saturated
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lcm_pkg::lcm_params_t params;
  lcm_pkg::lcm_item_t   head;
  logic                 head_valid;
  logic                 pop;

  // registers are written without wait states
  assign pready = 1'b1;

  // sizes, keep-aspect flag and the derived per-axis constants
  lcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .params  (params)
  );

  // front: takes each transfer, selects axis constants, folds the band sign
  lcm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .params     (params),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: forward multiply or reverse divide, then saturation
  lcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

@@ hdl/lcm_checker.sv @@
// ----------------------------------------------------------------------------
// lcm_checker
// port-level checks of the letterbox mapper
// ----------------------------------------------------------------------------
module lcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a clipped result sits on one of the two limits
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
    else $error("saturated result off the limits");

  // derivation runs after reset with input closed and no result shown
  a_rst: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("ready or valid after reset");

  // a register write closes the input while constants are re-derived
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[4:2] <= 3'd4 |=> !s_tready)
    else $error("input open during derivation");

endmodule

bind letterbox_coordinate_map_unit lcm_checker u_lcm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr)
);
